// ----- rtl/core/smx_pkg.sv -----
package smx_pkg;

	localparam int WORD_W      = 32;
	localparam int MODE_W      = 4;
	localparam int REGSEL_W    = 2;
	localparam int SHIFT_W     = 5;
	localparam int DEPTH_W     = 7;
	localparam int STATUS_W    = 2;

	localparam int STACK_DEPTH = 64;
	localparam int NUM_REGS    = 4;

	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int REG_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int DIV_CNT_W   = $clog2(WORD_W);

	typedef enum logic [MODE_W-1:0] {
		M_PUSH    = 4'd0,
		M_POP     = 4'd1,
		M_ADD     = 4'd2,
		M_SUB     = 4'd3,
		M_MUL     = 4'd4,
		M_DIV     = 4'd5,
		M_LEA     = 4'd6,
		M_LOADREG = 4'd7,
		M_PUSHREG = 4'd8,
		M_POPREG  = 4'd9,
		M_INC     = 4'd10,
		M_DEC     = 4'd11
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_UNDER = 2'd1,
		STAT_OVER  = 2'd2,
		STAT_DIVZ  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_start;
		logic div_load;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- rtl/core/smx_channels.sv -----
interface smx_req_if import smx_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [WORD_W-1:0]   immediate;
	logic [REGSEL_W-1:0]        reg_select;
	logic [SHIFT_W-1:0]         shift_amount;

	modport source (output valid, mode, immediate, reg_select, shift_amount, input ready);
	modport sink   (input valid, mode, immediate, reg_select, shift_amount, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [WORD_W-1:0]   result_value;
	logic [DEPTH_W-1:0]         depth_after;
	logic [STATUS_W-1:0]        status;
	logic                       reg_positive;

	modport source (output valid, result_value, depth_after, status, reg_positive, input ready);
	modport sink   (input valid, result_value, depth_after, status, reg_positive, output ready);
endinterface

// ----- rtl/core/smx_div.sv -----
module smx_div import smx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    quo_q;
	logic [WORD_W-1:0]    dvs_q;
	logic                 neg_q;
	logic [WORD_W:0]      shifted;
	logic [WORD_W+1:0]    trial;

	assign shifted  = {rem_q, quo_q[WORD_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dvs_q};
	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + WORD_W'(1)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
			dvs_q <= divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
		end else if (busy_q) begin
			if (trial[WORD_W+1]) begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end
		end
	end

endmodule

// ----- rtl/core/smx_ctrl.sv -----
module smx_ctrl import smx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_load = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/smx_datapath.sv -----
module smx_datapath import smx_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	output dp_stat_t                 stat,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [WORD_W-1:0] immediate,
	input  logic [REGSEL_W-1:0]      reg_select,
	input  logic [SHIFT_W-1:0]       shift_amount,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic signed [WORD_W-1:0] result_value,
	output logic [DEPTH_W-1:0]       depth_after,
	output logic [STATUS_W-1:0]      status,
	output logic                     reg_positive
);

	logic [WORD_W-1:0]   stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0]   rd_top_q;
	logic [WORD_W-1:0]   rd_sec_q;
	logic [CNT_W-1:0]    count_q;
	logic [WORD_W-1:0]   regs_q [NUM_REGS];

	mode_t               mode_q;
	logic [WORD_W-1:0]   imm_q;
	logic [REG_W-1:0]    ridx_q;
	logic [SHIFT_W-1:0]  sh_q;
	logic [WORD_W-1:0]   res_q;
	status_t             stat_q;

	logic                out_valid_q;
	logic [WORD_W-1:0]   out_res_q;
	logic [DEPTH_W-1:0]  out_depth_q;
	status_t             out_stat_q;
	logic                out_pos_q;

	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    cnt_m2;
	logic [STACK_AW-1:0] top_addr;
	logic [STACK_AW-1:0] sec_addr;
	logic [WORD_W-1:0]   reg_val;
	logic [WORD_W-1:0]   product;
	logic [WORD_W-1:0]   exec_res;
	status_t             exec_stat;
	logic                div_done;
	logic [WORD_W-1:0]   div_quo;

	logic                ok;
	logic [CNT_W-1:0]    count_d;
	logic                mem_we;
	logic [STACK_AW-1:0] mem_waddr;
	logic                reg_we;
	logic [WORD_W-1:0]   reg_new;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign cnt_m2   = count_q - CNT_W'(2);
	assign top_addr = cnt_m1[STACK_AW-1:0];
	assign sec_addr = cnt_m2[STACK_AW-1:0];
	assign reg_val  = regs_q[ridx_q];
	assign product  = rd_top_q * rd_sec_q;

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_top_q),
		.divisor  (rd_sec_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		rd_top_q <= stack_mem[top_addr];
		rd_sec_q <= stack_mem[sec_addr];
		if (mem_we) begin
			stack_mem[mem_waddr] <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			imm_q  <= immediate;
			ridx_q <= REG_W'(32'(reg_select) % NUM_REGS);
			sh_q   <= shift_amount;
		end
		if (cmd.exec) begin
			res_q  <= exec_res;
			stat_q <= exec_stat;
		end else if (cmd.div_load) begin
			res_q <= div_quo;
		end
	end

	always_comb begin
		exec_res  = '0;
		exec_stat = STAT_OK;
		unique case (mode_q)
			M_PUSH, M_PUSHREG: begin
				if (count_q >= CNT_W'(STACK_DEPTH)) begin
					exec_stat = STAT_OVER;
				end else begin
					exec_res = (mode_q == M_PUSH) ? imm_q : reg_val;
				end
			end
			M_POP, M_POPREG: begin
				if (count_q == '0) begin
					exec_stat = STAT_UNDER;
				end else begin
					exec_res = rd_top_q;
				end
			end
			M_ADD, M_SUB, M_MUL, M_DIV, M_LEA: begin
				if (count_q < CNT_W'(2)) begin
					exec_stat = STAT_UNDER;
				end else if (mode_q == M_DIV && rd_sec_q == '0) begin
					exec_stat = STAT_DIVZ;
				end else begin
					priority case (mode_q)
						M_ADD:   exec_res = rd_top_q + rd_sec_q;
						M_SUB:   exec_res = rd_top_q - rd_sec_q;
						M_MUL:   exec_res = product;
						M_LEA:   exec_res = rd_top_q + (rd_sec_q << sh_q);
						default: exec_res = '0;
					endcase
				end
			end
			M_LOADREG: exec_res = imm_q;
			M_INC:     exec_res = reg_val + WORD_W'(1);
			M_DEC:     exec_res = reg_val - WORD_W'(1);
			default:   exec_res = '0;
		endcase
	end

	assign stat.need_div = (mode_q == M_DIV) && (count_q >= CNT_W'(2)) && (rd_sec_q != '0);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !rsp_ready;

	always_comb begin
		ok        = (stat_q == STAT_OK);
		count_d   = count_q;
		mem_we    = 1'b0;
		mem_waddr = count_q[STACK_AW-1:0];
		reg_we    = 1'b0;
		unique case (mode_q)
			M_PUSH, M_PUSHREG: begin
				mem_we  = cmd.commit && ok;
				count_d = ok ? count_q + CNT_W'(1) : count_q;
			end
			M_POP: count_d = ok ? cnt_m1 : count_q;
			M_POPREG: begin
				count_d = ok ? cnt_m1 : count_q;
				reg_we  = ok;
			end
			M_ADD, M_SUB, M_MUL, M_DIV, M_LEA: begin
				mem_we    = cmd.commit && ok;
				mem_waddr = sec_addr;
				count_d   = ok ? cnt_m1 : count_q;
			end
			M_LOADREG, M_INC, M_DEC: reg_we = 1'b1;
			default: reg_we = 1'b0;
		endcase
		reg_new = reg_we ? res_q : reg_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			count_q <= count_d;
			if (reg_we) begin
				regs_q[ridx_q] <= res_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_res_q   <= res_q;
			out_depth_q <= DEPTH_W'(count_d);
			out_stat_q  <= stat_q;
			out_pos_q   <= !reg_new[WORD_W-1] && (reg_new != '0);
		end
	end

	assign rsp_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign depth_after  = out_depth_q;
	assign status       = out_stat_q;
	assign reg_positive = out_pos_q;

endmodule

// ----- rtl/core/stack_machine_execute.sv -----
// Sequence: a request beat is captured, executed and committed to a registered
// result beat; a divide waits for the 32-step radix-2 divider between execute and commit.
// One instruction is in flight at a time: the next request is taken only after
// the commit, which stalls while the previous result beat is still pending.
// Reset: arst_n clears the stack depth, the register file, the controller
// and the output beat; stack memory contents stay undefined until pushed.
module stack_machine_execute import smx_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	smx_req_if.sink   req,
	smx_rsp_if.source rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	smx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	smx_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (req.mode),
		.immediate    (req.immediate),
		.reg_select   (req.reg_select),
		.shift_amount (req.shift_amount),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.result_value (rsp.result_value),
		.depth_after  (rsp.depth_after),
		.status       (rsp.status),
		.reg_positive (rsp.reg_positive)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp.valid || rsp.ready))
		else $error("result beat overwritten while pending");

	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("result beat raised without a commit");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.depth_after <= DEPTH_W'(STACK_DEPTH)))
		else $error("stack depth beyond capacity");

	a_accept_single: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an instruction is in flight");

endmodule

// ----- bench/stack_machine_execute_test.sv -----
module stack_machine_execute_test;
	import smx_pkg::*;

	localparam int IDLE_PCT       = 27;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int STALL_LIMIT    = 2000;
	localparam int TAIL_CYCLES    = 60;
	localparam int SEGMENT_LEN    = 96;
	localparam int CALM_FROM      = 300;
	localparam int CALM_TO        = 450;

	localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = 4'd12;
	localparam logic [MODE_W-1:0] MODE_LAST_UNUSED  = 4'd15;
	localparam logic [WORD_W-1:0] MOST_NEG          = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MOST_POS          = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] MINUS_ONE         = 32'hFFFF_FFFF;

	typedef enum int {
		GROW,
		MIXED,
		SHRINK
	} phase_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [WORD_W-1:0]   immediate;
		logic [REGSEL_W-1:0] reg_select;
		logic [SHIFT_W-1:0]  shift_amount;
	} instr_t;

	typedef struct packed {
		logic [WORD_W-1:0]  value;
		logic [DEPTH_W-1:0] depth;
		status_t            status;
		logic               reg_pos;
	} outcome_t;

	logic clk;
	logic arst_n;

	smx_req_if req_ch();
	smx_rsp_if rsp_ch();

	stack_machine_execute u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [WORD_W-1:0] stack_words [STACK_DEPTH];
	int                stack_count;
	logic [WORD_W-1:0] reg_bank [NUM_REGS];

	instr_t   instr_queue [$];
	outcome_t expected_outcomes [$];

	logic     req_fired;
	int       accepted;
	int       stall_cycles;
	int       mismatches;
	int       divides;
	int       max_depth;
	int       status_seen [4];
	logic     calm;
	outcome_t want;
	outcome_t got;
	instr_t   beat;

	assign calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic outcome_t execute_instr(instr_t ins);
		outcome_t          o;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		longint            quotient;
		int                r;
		o.value  = '0;
		o.status = STAT_OK;
		r        = int'(ins.reg_select) % NUM_REGS;
		case (ins.mode)
			M_PUSH, M_PUSHREG: begin
				if (stack_count >= STACK_DEPTH) begin
					o.status = STAT_OVER;
				end else begin
					o.value = (ins.mode == M_PUSH) ? ins.immediate : reg_bank[r];
					stack_words[stack_count] = o.value;
					stack_count++;
				end
			end
			M_POP, M_POPREG: begin
				if (stack_count == 0) begin
					o.status = STAT_UNDER;
				end else begin
					stack_count--;
					o.value = stack_words[stack_count];
					if (ins.mode == M_POPREG)
						reg_bank[r] = o.value;
				end
			end
			M_ADD, M_SUB, M_MUL, M_DIV, M_LEA: begin
				if (stack_count < 2) begin
					o.status = STAT_UNDER;
				end else begin
					a = stack_words[stack_count-1];
					b = stack_words[stack_count-2];
					if (ins.mode == M_DIV)
						divides++;
					if (ins.mode == M_DIV && b == '0) begin
						o.status = STAT_DIVZ;
					end else begin
						case (ins.mode)
							M_ADD: o.value = a + b;
							M_SUB: o.value = a - b;
							M_MUL: o.value = a * b;
							M_DIV: begin
								quotient = longint'($signed(a)) / longint'($signed(b));
								o.value  = quotient[WORD_W-1:0];
							end
							default: o.value = a + (b << ins.shift_amount);
						endcase
						stack_count--;
						stack_words[stack_count-1] = o.value;
					end
				end
			end
			M_LOADREG: begin
				reg_bank[r] = ins.immediate;
				o.value     = ins.immediate;
			end
			M_INC: begin
				reg_bank[r] = reg_bank[r] + 1'b1;
				o.value     = reg_bank[r];
			end
			M_DEC: begin
				reg_bank[r] = reg_bank[r] - 1'b1;
				o.value     = reg_bank[r];
			end
			default: ;
		endcase
		o.depth   = stack_count[DEPTH_W-1:0];
		o.reg_pos = (reg_bank[r] != '0) && !reg_bank[r][WORD_W-1];
		if (stack_count > max_depth)
			max_depth = stack_count;
		status_seen[o.status]++;
		return o;
	endfunction

	task automatic queue_instr(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] imm,
			input int rsel, input int sh);
		instr_t ins;
		ins.mode         = m;
		ins.immediate    = imm;
		ins.reg_select   = rsel[REGSEL_W-1:0];
		ins.shift_amount = sh[SHIFT_W-1:0];
		instr_queue.push_back(ins);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 12)
			return '0;
		else if (roll < 18)
			return 32'd1;
		else if (roll < 24)
			return MINUS_ONE;
		else if (roll < 29)
			return MOST_NEG;
		else if (roll < 34)
			return MOST_POS;
		else if (roll < 55)
			return WORD_W'($signed($urandom_range(200, 0)) - 100);
		return $urandom();
	endfunction

	function automatic instr_t random_instr(phase_t phase);
		instr_t            ins;
		logic [MODE_W-1:0] binops [5];
		int                roll;
		int                cut [7];
		binops = '{M_ADD, M_SUB, M_MUL, M_DIV, M_LEA};
		case (phase)
			GROW:    cut = '{55, 70, 78, 82, 85, 91, 97};
			MIXED:   cut = '{25, 32, 62, 72, 77, 85, 96};
			default: cut = '{8, 12, 52, 72, 82, 88, 97};
		endcase
		roll             = $urandom_range(99, 0);
		ins.immediate    = pick_word();
		ins.reg_select   = REGSEL_W'($urandom_range(NUM_REGS - 1, 0));
		ins.shift_amount = SHIFT_W'($urandom_range(31, 0));
		if (roll < cut[0])
			ins.mode = M_PUSH;
		else if (roll < cut[1])
			ins.mode = M_PUSHREG;
		else if (roll < cut[2])
			ins.mode = binops[$urandom_range(4, 0)];
		else if (roll < cut[3])
			ins.mode = M_POP;
		else if (roll < cut[4])
			ins.mode = M_POPREG;
		else if (roll < cut[5])
			ins.mode = M_LOADREG;
		else if (roll < cut[6])
			ins.mode = $urandom_range(1, 0) ? M_INC : M_DEC;
		else
			ins.mode = MODE_W'($urandom_range(MODE_LAST_UNUSED, MODE_FIRST_UNUSED));
		return ins;
	endfunction

	task automatic drain();
		while (instr_queue.size() != 0 || req_ch.valid || expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// request driver: hold until taken, otherwise advance or idle
	always @(negedge clk) begin
		if (arst_n && !(req_ch.valid && !req_fired)) begin
			if (instr_queue.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
				beat = instr_queue.pop_front();
				req_ch.valid        <= 1'b1;
				req_ch.mode         <= beat.mode;
				req_ch.immediate    <= beat.immediate;
				req_ch.reg_select   <= beat.reg_select;
				req_ch.shift_amount <= beat.shift_amount;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			rsp_ch.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_fired <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				expected_outcomes.push_back(execute_instr(
					{req_ch.mode, req_ch.immediate, req_ch.reg_select, req_ch.shift_amount}));
				accepted++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.result_value, rsp_ch.depth_after, status_t'(rsp_ch.status),
					rsp_ch.reg_positive};
				if (expected_outcomes.size() == 0) begin
					$error("unexpected result beat: result_value %0d depth_after %0d",
						$signed(got.value), got.depth);
					mismatches++;
				end else begin
					want = expected_outcomes.pop_front();
					if (got.value !== want.value) begin
						$error("result_value: expected %0d, actual %0d",
							$signed(want.value), $signed(got.value));
						mismatches++;
					end
					if (got.depth !== want.depth) begin
						$error("depth_after: expected %0d, actual %0d", want.depth, got.depth);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						mismatches++;
					end
					if (got.reg_pos !== want.reg_pos) begin
						$error("reg_positive: expected %0d, actual %0d", want.reg_pos,
							got.reg_pos);
						mismatches++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int     n;
		int     i;
		instr_t ins;
		arst_n              = 1'b0;
		req_fired           = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = '0;
		req_ch.immediate    = '0;
		req_ch.reg_select   = '0;
		req_ch.shift_amount = '0;
		rsp_ch.ready        = 1'b0;
		accepted            = 0;
		stall_cycles        = 0;
		mismatches          = 0;
		divides             = 0;
		max_depth           = 0;
		status_seen         = '{0, 0, 0, 0};
		stack_count         = 0;
		for (int k = 0; k < NUM_REGS; k++)
			reg_bank[k] = '0;
		for (int k = 0; k < STACK_DEPTH; k++)
			stack_words[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_instr(M_POP, MOST_POS, 0, 0);
		queue_instr(M_ADD, '0, 1, 31);
		queue_instr(M_POPREG, '0, 2, 0);
		queue_instr(MODE_FIRST_UNUSED, MINUS_ONE, 3, 31);
		queue_instr(MODE_LAST_UNUSED, MOST_NEG, 0, 0);
		queue_instr(M_LOADREG, MOST_POS, 0, 0);
		queue_instr(M_INC, '0, 0, 0);
		queue_instr(M_DEC, '0, 0, 0);
		queue_instr(M_LOADREG, MOST_NEG, 1, 0);
		queue_instr(M_DEC, '0, 1, 0);
		queue_instr(M_LOADREG, '0, 3, 0);
		queue_instr(M_PUSH, '0, 0, 0);
		queue_instr(M_PUSH, MOST_NEG, 0, 0);
		queue_instr(M_DIV, '0, 0, 0);
		queue_instr(M_POP, '0, 0, 0);
		queue_instr(M_PUSH, MINUS_ONE, 0, 0);
		queue_instr(M_PUSH, MOST_NEG, 0, 0);
		queue_instr(M_DIV, '0, 0, 0);
		queue_instr(M_PUSH, 32'd7, 0, 0);
		queue_instr(M_SUB, '0, 0, 0);
		queue_instr(M_PUSH, MOST_POS, 0, 0);
		queue_instr(M_MUL, '0, 0, 0);
		queue_instr(M_PUSH, 32'd3, 0, 0);
		queue_instr(M_LEA, '0, 0, 31);
		queue_instr(M_PUSHREG, '0, 0, 0);
		queue_instr(M_POPREG, '0, 2, 0);
		queue_instr(M_PUSH, 32'd2, 0, 0);
		queue_instr(M_PUSH, 32'hFFFF_FFF9, 0, 0);
		queue_instr(M_DIV, '0, 0, 0);
		drain();

		n = 0;
		i = 0;
		while (n < RANDOM_ITEMS) begin
			ins = random_instr(phase_t'((i / SEGMENT_LEN) % 3));
			instr_queue.push_back(ins);
			if (ins.mode <= M_DEC)
				n++;
			i++;
			if (i == 400 || i == 800)
				drain();
		end
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Executed %0d instructions, %0d divides; ", accepted, divides,
			"underflow %0d, overflow %0d, divide by zero %0d",
			status_seen[STAT_UNDER], status_seen[STAT_OVER], status_seen[STAT_DIVZ]);
		$display("Deepest stack reached: %0d of %0d entries", max_depth, STACK_DEPTH);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
